@@ sv/mmc3mc_pkg.sv @@
// Shared types and constants for the MMC3 multicart bank mapper.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package mmc3mc_pkg;

    localparam int unsigned InDataW  = 32;
    localparam int unsigned OutDataW = 16;
    localparam int unsigned OpW      = 2;
    localparam int unsigned AddrW    = 16;
    localparam int unsigned ValueW   = 8;
    localparam int unsigned PrgBankW = 8;
    localparam int unsigned ChrBankW = 9;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 9;

    localparam logic [PrgBankW-1:0] PrgLimitReset = 8'd31;
    localparam logic [ChrBankW-1:0] ChrLimitReset = 9'd511;

    localparam logic [AddrW-1:0] SelMask    = 16'hE001;
    localparam logic [AddrW-1:0] SelBankSel = 16'h8000;
    localparam logic [AddrW-1:0] SelBankReg = 16'h8001;
    localparam logic [3:0]       OuterPage  = 4'h6;

    typedef enum logic [OpW-1:0] {
        OP_CPU_WRITE  = 2'd0,
        OP_PRG_LOOKUP = 2'd1,
        OP_CHR_LOOKUP = 2'd2,
        OP_RESERVED   = 2'd3
    } t_op;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PRG_LIMIT = 1'b0,
        CFG_CHR_LIMIT = 1'b1
    } t_cfg_idx;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic load_item;
        logic execute;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ sv/mmc3mc_ctrl.sv @@
// Controller for the MMC3 multicart bank mapper: item handshake and output valid.
// Depends on mmc3mc_pkg; drives the datapath through a t_dp_cmd struct.
`default_nettype none

module mmc3mc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mmc3mc_pkg::t_dp_cmd  o_cmd
);
    import mmc3mc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOADED = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_execute;

    assign w_execute       = (r_state == S_LOADED) && (!r_out_valid || i_out_ready);
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute   = w_execute;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOADED;
                end
            end
            S_LOADED: begin
                if (w_execute) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ sv/mmc3mc_dp.sv @@
// Datapath for the MMC3 multicart bank mapper: mapper registers, limits,
// PRG/CHR translation and the result register. Depends on mmc3mc_pkg.
`default_nettype none

module mmc3mc_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  mmc3mc_pkg::t_dp_cmd                i_cmd,
    input  wire  [mmc3mc_pkg::OpW-1:0]         i_op,
    input  wire  [mmc3mc_pkg::AddrW-1:0]       i_addr,
    input  wire  [mmc3mc_pkg::ValueW-1:0]      i_value,
    input  wire                                i_wr_ok,
    input  wire                                i_cfg_we,
    input  wire  [mmc3mc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire  [mmc3mc_pkg::CfgDataW-1:0]    i_cfg_data,
    output logic [mmc3mc_pkg::ChrBankW-1:0]    o_bank,
    output logic                               o_handled
);
    import mmc3mc_pkg::*;

    logic [OpW-1:0]      r_op;
    logic [AddrW-1:0]    r_addr;
    t_byte               r_value;
    logic                r_wr_ok;

    t_byte               r_outer;
    t_byte               r_bsel;
    t_byte               r_breg [8];
    logic [PrgBankW-1:0] r_prg_lim;
    logic [ChrBankW-1:0] r_chr_lim;
    logic [ChrBankW-1:0] r_bank;
    logic                r_handled;

    logic [1:0]          w_prg_slot;
    logic [2:0]          w_chr_slot;
    logic [2:0]          w_rd_idx;
    t_byte               w_rd;
    logic [3:0]          w_prg_inner;
    logic [3:0]          w_base;
    logic [PrgBankW-1:0] w_prg_raw;
    logic [PrgBankW-1:0] w_prg_bank;
    t_byte               w_chr_inner;
    logic [ChrBankW-1:0] w_chr_raw;
    logic [ChrBankW-1:0] w_chr_bank;
    logic                w_outer_hit;
    logic                w_bsel_hit;
    logic                w_breg_hit;
    logic [ChrBankW-1:0] n_bank;
    logic                n_handled;

    assign w_prg_slot = r_addr[14:13];
    assign w_chr_slot = r_addr[12:10] ^ {r_bsel[7], 2'b00};

    always_comb begin
        if (t_op'(r_op) == OP_PRG_LOOKUP) begin
            w_rd_idx = (w_prg_slot == 2'd1) ? 3'd7 : 3'd6;
        end else if (!w_chr_slot[2]) begin
            w_rd_idx = {2'b00, w_chr_slot[1]};
        end else begin
            w_rd_idx = {1'b0, w_chr_slot[1:0]} + 3'd2;
        end
    end

    assign w_rd = r_breg[w_rd_idx];

    always_comb begin
        case (w_prg_slot)
            2'd0:    w_prg_inner = r_bsel[6] ? 4'hE : w_rd[3:0];
            2'd1:    w_prg_inner = w_rd[3:0];
            2'd2:    w_prg_inner = r_bsel[6] ? w_rd[3:0] : 4'hE;
            default: w_prg_inner = 4'hF;
        endcase
    end

    assign w_base = {r_outer[4], r_outer[3] | r_outer[6], r_outer[2], r_outer[1]};

    always_comb begin
        if (r_outer[5]) begin
            w_prg_raw = {2'b00, w_base, w_prg_slot};
        end else begin
            w_prg_raw = {3'b000, r_outer[6], w_prg_inner};
        end
        w_prg_bank = (w_prg_raw > r_prg_lim) ? (w_prg_raw & r_prg_lim) : w_prg_raw;
    end

    always_comb begin
        if (!w_chr_slot[2]) begin
            w_chr_inner = {w_rd[7:1], w_chr_slot[0]};
        end else begin
            w_chr_inner = w_rd;
        end
        w_chr_raw  = {r_outer[6], w_chr_inner};
        w_chr_bank = (w_chr_raw > r_chr_lim) ? (w_chr_raw & r_chr_lim) : w_chr_raw;
    end

    assign w_outer_hit = (r_addr[15:12] == OuterPage);
    assign w_bsel_hit  = r_addr[15] && ((r_addr & SelMask) == SelBankSel);
    assign w_breg_hit  = r_addr[15] && ((r_addr & SelMask) == SelBankReg);

    always_comb begin
        n_bank    = '0;
        n_handled = 1'b0;
        case (t_op'(r_op))
            OP_CPU_WRITE: begin
                n_handled = w_outer_hit || w_bsel_hit || w_breg_hit;
            end
            OP_PRG_LOOKUP: begin
                if (r_addr[15]) begin
                    n_bank    = {1'b0, w_prg_bank};
                    n_handled = 1'b1;
                end
            end
            OP_CHR_LOOKUP: begin
                if (r_addr[15:13] == 3'b000) begin
                    n_bank    = w_chr_bank;
                    n_handled = 1'b1;
                end
            end
            default: begin
                n_bank    = '0;
                n_handled = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_addr  <= i_addr;
            r_value <= i_value;
            r_wr_ok <= i_wr_ok;
        end
        if (i_cmd.execute) begin
            r_bank    <= n_bank;
            r_handled <= n_handled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer   <= '0;
            r_bsel    <= '0;
            r_breg[0] <= 8'd0;
            r_breg[1] <= 8'd2;
            r_breg[2] <= 8'd4;
            r_breg[3] <= 8'd5;
            r_breg[4] <= 8'd6;
            r_breg[5] <= 8'd7;
            r_breg[6] <= 8'd0;
            r_breg[7] <= 8'd0;
            r_prg_lim <= PrgLimitReset;
            r_chr_lim <= ChrLimitReset;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PRG_LIMIT: r_prg_lim <= i_cfg_data[PrgBankW-1:0];
                    CFG_CHR_LIMIT: r_chr_lim <= i_cfg_data;
                    default:       r_prg_lim <= r_prg_lim;
                endcase
            end
            if (i_cmd.execute && (t_op'(r_op) == OP_CPU_WRITE)) begin
                if (w_outer_hit && r_wr_ok) begin
                    r_outer <= r_value;
                end
                if (w_bsel_hit) begin
                    r_bsel <= r_value;
                end
                if (w_breg_hit) begin
                    r_breg[r_bsel[2:0]] <= r_value;
                end
            end
        end
    end

    assign o_bank    = r_bank;
    assign o_handled = r_handled;

endmodule

`default_nettype wire

@@ sv/mmc3_multicart_bank_mapper.sv @@
// Top level of the MMC3 multicart bank mapper.
// Depends on mmc3mc_pkg, mmc3mc_ctrl and mmc3mc_dp.
//
// Usage:
//   Slave stream: s_axis_tuser carries the operation (CPU write, PRG lookup,
//   CHR lookup); s_axis_tdata carries address, value and PRG RAM write enable.
//   Master stream: one item per input item; m_axis_tdata carries the bank,
//   m_axis_tuser the handled flag.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index selecting the PRG
//   (0) or CHR (1) bank limit; o_cfg_ready is always high.
//   Result path: the input item is loaded into the holding register on the edge
//   that accepts it and translated into the result register once that is free.
//   Flow: a new item is accepted only after the held item has been translated
//   into the result register; the mapper registers update as the held item
//   is translated.
//   Reset: limits return to 31 and 511, outer register and bank select to zero,
//   bank registers to 0,2,4,5,6,7,0,0; no result is pending.
//   Stall: while m_axis_tready is low the result holds; one further item may be
//   accepted and waits in the holding register until the result is taken.
`default_nettype none

module mmc3_multicart_bank_mapper (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] address, [23:16] value, [24] prg_ram_writable, [31:25] zero
    input  wire  [mmc3mc_pkg::InDataW-1:0]      s_axis_tdata,
    // [1:0] operation
    input  wire  [mmc3mc_pkg::OpW-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [8:0] bank, [15:9] zero
    output logic [mmc3mc_pkg::OutDataW-1:0]     m_axis_tdata,
    // [0] handled
    output logic                                m_axis_tuser,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mmc3mc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire  [mmc3mc_pkg::CfgDataW-1:0]     i_cfg_data
);
    import mmc3mc_pkg::*;

    t_dp_cmd               w_cmd;
    logic [ChrBankW-1:0]   w_bank;
    logic                  w_handled;

    assign o_cfg_ready = 1'b1;

    mmc3mc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    mmc3mc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (s_axis_tuser),
        .i_addr      (s_axis_tdata[15:0]),
        .i_value     (s_axis_tdata[23:16]),
        .i_wr_ok     (s_axis_tdata[24]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bank      (w_bank),
        .o_handled   (w_handled)
    );

    assign m_axis_tdata = {{(OutDataW - ChrBankW){1'b0}}, w_bank};
    assign m_axis_tuser = w_handled;

endmodule

`default_nettype wire
